// File: rtl/iol_pkg.sv
package iol_pkg;

	localparam int unsigned PosWidth   = 5;
	localparam int unsigned ValueWidth = 32;
	localparam int unsigned DepthDflt  = 16;

	localparam logic [2:0] OP_INSERT_AT  = 3'd0;
	localparam logic [2:0] OP_DELETE_AT  = 3'd1;
	localparam logic [2:0] OP_INSERT_END = 3'd2;
	localparam logic [2:0] OP_DELETE_END = 3'd3;
	localparam logic [2:0] OP_READ_AT    = 3'd4;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]                   operation;
		logic [PosWidth-1:0]          position;
		logic signed [ValueWidth-1:0] item_value;
	} iol_req_t;

	typedef struct packed {
		logic [1:0]                   status;
		logic [PosWidth-1:0]          element_count;
		logic signed [ValueWidth-1:0] read_value;
	} iol_rsp_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic                         ins;
		logic                         del;
		logic signed [ValueWidth-1:0] value;
	} iol_cmd_t;

endpackage

// File: rtl/indexed_ordered_list_unit.sv
// Ordered list of up to DEPTH signed 32-bit values.
//
// Request channel (request_valid / request_stall / request) carries one
// operation: insert at index, delete at index, insert at end, delete at end
// or read at index. Result channel (result_valid / result_stall / result)
// returns one status, the element count after the operation and the value
// read (zero unless a read succeeds).
//
// For each request, the controller decodes it against the fill
// count while every cell of the row compares its own position with the
// index, and on the clock edge each cell holds, takes the new value, or
// copies from its left or right neighbour. The result sits in an output
// register in the cycle after acceptance, and a new request is taken in every
// cycle that register is free or being emptied: one request per cycle.
//
// Reset empties the list (fill count zero) and drops any pending result;
// cell contents are not cleared and are only read below the fill count.
// While the receiver stalls with a result waiting, request_stall is raised.
module indexed_ordered_list_unit import iol_pkg::*; #(
	parameter int unsigned DEPTH = DepthDflt
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     request_valid,
	output logic     request_stall,
	input  iol_req_t request,
	output logic     result_valid,
	input  logic     result_stall,
	output iol_rsp_t result
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                         accept;
	iol_cmd_t                     cmd;
	logic [CW-1:0]                idx;
	logic [1:0]                   status;
	logic                         rd_ok;
	logic [CW-1:0]                count;
	logic [CW-1:0]                next_count;
	logic signed [ValueWidth-1:0] cell_val [DEPTH];
	logic signed [ValueWidth-1:0] rd_val;

	logic     out_valid_q;
	iol_rsp_t out_q;

	// hold requests only while a result waits and the receiver stalls
	assign request_stall = out_valid_q && result_stall;
	assign accept        = request_valid && !request_stall;

	iol_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.req        (request),
		.cmd        (cmd),
		.idx        (idx),
		.status     (status),
		.rd_ok      (rd_ok),
		.count      (count),
		.next_count (next_count)
	);

	// row of cells; the ends feed back their own value as the missing neighbour
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		iol_cell #(.CW(CW), .POS(i)) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.idx   (idx),
			.left  (cell_val[(i == 0) ? 0 : i - 1]),
			.right (cell_val[(i == DEPTH - 1) ? i : i + 1]),
			.value (cell_val[i])
		);
	end

	// read select; only used when the position lies below the count
	assign rd_val = rd_ok ? cell_val[IW'(request.position)] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload: no reset, load on every accepted request
	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.status        <= status;
			out_q.element_count <= PosWidth'(next_count);
			out_q.read_value    <= rd_val;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// the fill count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(DEPTH))
		else $error("fill count above depth");

	// every accepted request yields a result on the next cycle
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result_valid)
		else $error("accepted request gave no result");

	// a full rejection reports a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.status == ST_FULL)) |->
		(result.element_count == PosWidth'(DEPTH)))
		else $error("full status with list not full");

	// a non-zero read value only comes with a successful operation
	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.read_value != '0)) |-> (result.status == ST_DONE))
		else $error("read value on failed request");

endmodule

// File: rtl/iol_cell.sv
module iol_cell import iol_pkg::*; #(
	parameter int unsigned CW  = 5,
	parameter int unsigned POS = 0
) (
	input  logic                         clk,
	input  iol_cmd_t                     cmd,
	input  logic [CW-1:0]                idx,
	input  logic signed [ValueWidth-1:0] left,
	input  logic signed [ValueWidth-1:0] right,
	output logic signed [ValueWidth-1:0] value
);

	localparam logic [CW-1:0] MyPos = CW'(POS);

	logic signed [ValueWidth-1:0] val_q;

	// insert: take the new value at the index, shift up above it
	// delete: pull down from the right at and above the index
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (MyPos == idx) begin
				val_q <= cmd.value;
			end else if (MyPos > idx) begin
				val_q <= left;
			end
		end else if (cmd.del && (MyPos >= idx)) begin
			val_q <= right;
		end
	end

	assign value = val_q;

endmodule

// File: rtl/iol_ctrl.sv
module iol_ctrl import iol_pkg::*; #(
	parameter int unsigned DEPTH = DepthDflt
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  iol_req_t                   req,
	output iol_cmd_t                   cmd,
	output logic [$clog2(DEPTH+1)-1:0] idx,
	output logic [1:0]                 status,
	output logic                       rd_ok,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic [$clog2(DEPTH+1)-1:0] next_count
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned MW = (CW > PosWidth) ? CW : PosWidth;
	localparam logic [MW-1:0] DepthM = MW'(DEPTH);

	logic [CW-1:0] count_q;
	logic [MW-1:0] pos_m;
	logic [MW-1:0] cnt_m;

	assign pos_m = MW'(req.position);
	assign cnt_m = MW'(count_q);

	always_comb begin
		cmd.ins    = 1'b0;
		cmd.del    = 1'b0;
		cmd.value  = req.item_value;
		idx        = CW'(pos_m);
		status     = ST_RANGE;
		rd_ok      = 1'b0;
		next_count = count_q;
		case (req.operation)
			OP_INSERT_AT, OP_INSERT_END: begin
				if (req.operation == OP_INSERT_END) begin
					idx = count_q;
				end
				if ((req.operation == OP_INSERT_AT) && (pos_m > cnt_m)) begin
					status = ST_RANGE;
				end else if (cnt_m >= DepthM) begin
					status = ST_FULL;
				end else begin
					status     = ST_DONE;
					cmd.ins    = accept;
					next_count = count_q + CW'(1);
				end
			end
			OP_DELETE_AT, OP_DELETE_END: begin
				if (req.operation == OP_DELETE_END) begin
					idx = count_q - CW'(1);
				end
				if ((req.operation == OP_DELETE_AT) ? (pos_m < cnt_m) : (count_q != '0)) begin
					status     = ST_DONE;
					cmd.del    = accept;
					next_count = count_q - CW'(1);
				end
			end
			OP_READ_AT: begin
				if (pos_m < cnt_m) begin
					status = ST_DONE;
					rd_ok  = 1'b1;
				end
			end
			default: begin
				status = ST_RANGE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= next_count;
		end
	end

	assign count = count_q;

endmodule

// File: sim/indexed_ordered_list_unit_test.sv
module indexed_ordered_list_unit_test;
	import iol_pkg::*;

	localparam int unsigned ListDepth = DepthDflt;

	// operation codes the block does not decode
	localparam logic [2:0] OpSpareLow  = 3'd5;
	localparam logic [2:0] OpSpareMid  = 3'd6;
	localparam logic [2:0] OpSpareHigh = 3'd7;

	// random-part shape
	localparam int PhaseItems  = 160;
	localparam int TrendLength = 40;
	localparam int HoldOffLen  = 80;

	// list trend within the random part
	localparam int TrendGrow    = 0;
	localparam int TrendShrink  = 1;
	localparam int TrendBalance = 2;

	logic     clk           = 1'b0;
	logic     arst_n        = 1'b0;
	logic     request_valid = 1'b0;
	logic     request_stall;
	iol_req_t request       = '0;
	logic     result_valid;
	logic     result_stall  = 1'b0;
	iol_rsp_t result;

	// what the list should hold, in index order
	logic signed [ValueWidth-1:0] shadow_list[$];
	// one entry per accepted request, in order of acceptance
	iol_rsp_t awaited_results[$];
	iol_rsp_t arrived_want;

	int errors         = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int holdoff_left   = 0;

	// directed requests, each row optionally repeated and optionally
	// carrying a hand-written result
	typedef struct {
		iol_req_t req;
		int       reps;
		bit       typed;
		iol_rsp_t want;
	} plan_row_t;

	plan_row_t plan[$];

	indexed_ordered_list_unit #(
		.DEPTH(ListDepth)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.request_valid(request_valid),
		.request_stall(request_stall),
		.request      (request),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Apply one request to the shadow list and return the result it should
	// produce. Range is checked before capacity, as the block does.
	function automatic iol_rsp_t list_outcome(iol_req_t req);
		iol_rsp_t rsp;
		int       n;
		int       pos;
		n = shadow_list.size();
		pos = req.position;
		rsp = '0;
		rsp.status = ST_DONE;
		case (req.operation)
			OP_INSERT_AT, OP_INSERT_END: begin
				if (req.operation == OP_INSERT_END)
					pos = n;
				if (pos > n)
					rsp.status = ST_RANGE;
				else if (n >= ListDepth)
					rsp.status = ST_FULL;
				else
					shadow_list.insert(pos, req.item_value);
			end
			OP_DELETE_AT: begin
				if (pos >= n)
					rsp.status = ST_RANGE;
				else
					shadow_list.delete(pos);
			end
			OP_DELETE_END: begin
				if (n == 0)
					rsp.status = ST_RANGE;
				else
					shadow_list.delete(n - 1);
			end
			OP_READ_AT: begin
				if (pos < n)
					rsp.read_value = shadow_list[pos];
				else
					rsp.status = ST_RANGE;
			end
			default: rsp.status = ST_RANGE;
		endcase
		rsp.element_count = PosWidth'(shadow_list.size());
		return rsp;
	endfunction

	function automatic void add_row(logic [2:0] op, logic [PosWidth-1:0] pos,
			logic [ValueWidth-1:0] val, int reps, bit typed, logic [1:0] st,
			logic [PosWidth-1:0] cnt, logic [ValueWidth-1:0] rd);
		plan_row_t row;
		row.req.operation     = op;
		row.req.position      = pos;
		row.req.item_value    = val;
		row.reps              = reps;
		row.typed             = typed;
		row.want.status        = st;
		row.want.element_count = cnt;
		row.want.read_value    = rd;
		plan.push_back(row);
	endfunction

	// Draw a request that mostly makes sense for the current list, with a
	// tenth of positions and a few operation codes thrown in as noise.
	function automatic iol_req_t random_request(int trend);
		iol_req_t req;
		int       n;
		int       pick;
		int       ins_w;
		int       del_w;
		n = shadow_list.size();
		pick = $urandom_range(99);
		case (trend)
			TrendGrow:   begin ins_w = 55; del_w = 20; end
			TrendShrink: begin ins_w = 20; del_w = 55; end
			default:     begin ins_w = 35; del_w = 35; end
		endcase
		req.position = PosWidth'($urandom_range(31));
		case ($urandom_range(7))
			0:       req.item_value = 32'sh8000_0000;
			1:       req.item_value = 32'sh7fff_ffff;
			2:       req.item_value = '0;
			3:       req.item_value = '1;
			default: req.item_value = $urandom;
		endcase
		if (pick < 3) begin
			case ($urandom_range(2))
				0:       req.operation = OpSpareLow;
				1:       req.operation = OpSpareMid;
				default: req.operation = OpSpareHigh;
			endcase
			return req;
		end
		pick = $urandom_range(99);
		if (pick < ins_w)
			req.operation = $urandom_range(1) ? OP_INSERT_AT : OP_INSERT_END;
		else if (pick < ins_w + del_w)
			req.operation = $urandom_range(1) ? OP_DELETE_AT : OP_DELETE_END;
		else
			req.operation = OP_READ_AT;
		// keep most indexed requests inside the list
		if ($urandom_range(9) != 0) begin
			if (req.operation == OP_INSERT_AT)
				req.position = PosWidth'($urandom_range(n));
			else if (req.operation == OP_DELETE_AT || req.operation == OP_READ_AT)
				req.position = (n > 0) ? PosWidth'($urandom_range(n - 1)) : '0;
		end
		return req;
	endfunction

	// Offer one request, hold it until taken, then record what it should
	// return. The gap before it follows the sender's idle rate.
	task automatic offer(iol_req_t req, bit typed, iol_rsp_t want);
		int       gap;
		iol_rsp_t predicted;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			request_valid <= 1'b0;
			request       <= iol_req_t'({$urandom, $urandom});
			repeat (gap) @(posedge clk);
		end
		request_valid <= 1'b1;
		request       <= req;
		do
			@(posedge clk);
		while (request_stall);
		predicted = list_outcome(req);
		awaited_results.push_back(typed ? want : predicted);
	endtask

	// Receiver: stall at the phase's rate, or hold off solidly when asked.
	initial begin
		forever begin
			@(posedge clk);
			if (holdoff_left > 0) begin
				result_stall <= 1'b1;
				holdoff_left--;
			end else begin
				result_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (awaited_results.size() == 0) begin
				$error("unexpected result: status %0d count %0d value %h",
					result.status, result.element_count, result.read_value);
				errors++;
			end else begin
				arrived_want = awaited_results.pop_front();
				if (result.status !== arrived_want.status) begin
					$error("status: expected %0d, got %0d",
						arrived_want.status, result.status);
					errors++;
				end
				if (result.element_count !== arrived_want.element_count) begin
					$error("element_count: expected %0d, got %0d",
						arrived_want.element_count, result.element_count);
					errors++;
				end
				if (result.read_value !== arrived_want.read_value) begin
					$error("read_value: expected %h, got %h",
						arrived_want.read_value, result.read_value);
					errors++;
				end
			end
		end
	end

	initial begin
		iol_req_t req;
		int       trend;
		int       phase;
		int       k;
		int       r;

		// Directed part. Rows marked typed carry their result by hand.
		add_row(OP_READ_AT,    5'd0,  32'h0,         1,  1, ST_RANGE, 5'd0,  32'h0);
		add_row(OP_DELETE_END, 5'd0,  32'h0,         1,  1, ST_RANGE, 5'd0,  32'h0);
		add_row(OP_DELETE_AT,  5'd0,  32'h0,         1,  1, ST_RANGE, 5'd0,  32'h0);
		add_row(OP_INSERT_AT,  5'd1,  32'h1234_5678, 1,  1, ST_RANGE, 5'd0,  32'h0);
		add_row(OP_INSERT_AT,  5'd0,  32'h7fff_ffff, 1,  1, ST_DONE,  5'd1,  32'h0);
		add_row(OP_READ_AT,    5'd0,  32'h0,         1,  1, ST_DONE,  5'd1,  32'h7fff_ffff);
		add_row(OP_INSERT_END, 5'd31, 32'h8000_0000, 1,  1, ST_DONE,  5'd2,  32'h0);
		add_row(OP_INSERT_AT,  5'd0,  32'hffff_ffff, 1,  0, ST_DONE,  5'd0,  32'h0);
		add_row(OP_INSERT_AT,  5'd2,  32'h5555_aaaa, 1,  0, ST_DONE,  5'd0,  32'h0);
		add_row(OP_READ_AT,    5'd3,  32'h0,         1,  0, ST_DONE,  5'd0,  32'h0);
		add_row(OP_READ_AT,    5'd2,  32'hffff_ffff, 1,  0, ST_DONE,  5'd0,  32'h0);
		add_row(OpSpareLow,    5'd0,  32'hffff_ffff, 1,  1, ST_RANGE, 5'd4,  32'h0);
		add_row(OpSpareHigh,   5'd31, 32'h0,         1,  1, ST_RANGE, 5'd4,  32'h0);
		add_row(OP_READ_AT,    5'd31, 32'h0,         1,  1, ST_RANGE, 5'd4,  32'h0);
		add_row(OP_DELETE_AT,  5'd1,  32'h0,         1,  0, ST_DONE,  5'd0,  32'h0);
		add_row(OP_DELETE_END, 5'd16, 32'h0,         1,  0, ST_DONE,  5'd0,  32'h0);
		// fill to the brim, then knock on a full list
		add_row(OP_INSERT_END, 5'd0,  32'hc0de_0001, 14, 0, ST_DONE,  5'd0,  32'h0);
		add_row(OP_INSERT_END, 5'd0,  32'h0bad_0001, 1,  1, ST_FULL,  5'd16, 32'h0);
		add_row(OP_INSERT_AT,  5'd16, 32'h0bad_0002, 1,  1, ST_FULL,  5'd16, 32'h0);
		add_row(OP_INSERT_AT,  5'd17, 32'h0bad_0003, 1,  1, ST_RANGE, 5'd16, 32'h0);
		add_row(OP_INSERT_AT,  5'd0,  32'h0bad_0004, 1,  1, ST_FULL,  5'd16, 32'h0);
		add_row(OP_READ_AT,    5'd15, 32'h0,         1,  0, ST_DONE,  5'd0,  32'h0);
		add_row(OP_DELETE_AT,  5'd15, 32'h0,         1,  1, ST_DONE,  5'd15, 32'h0);
		add_row(OP_DELETE_AT,  5'd0,  32'h0,         1,  0, ST_DONE,  5'd0,  32'h0);
		add_row(OpSpareMid,    5'd16, 32'h0,         1,  1, ST_RANGE, 5'd14, 32'h0);

		// hold reset, then release it once
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			for (k = 0; k < plan[i].reps; k++) begin
				req = plan[i].req;
				// vary the value on repeated inserts so a shift error shows
				req.item_value = req.item_value + k;
				offer(req, plan[i].typed, plan[i].want);
			end
		end

		// Random part in five phases: steady, sender idling, receiver
		// stalling, both idling lightly, then steady with a long hold-off.
		trend = TrendGrow;
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				1:       begin send_idle_pct = 82; recv_stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  recv_stall_pct = 82; end
				3:       begin send_idle_pct = 20; recv_stall_pct = 20; end
				default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			endcase
			// back the block up: results wait while requests keep coming
			if (phase == 4)
				holdoff_left = HoldOffLen;
			for (r = 0; r < PhaseItems; r++) begin
				if (r % TrendLength == 0)
					trend = $urandom_range(TrendBalance);
				offer(random_request(trend), 1'b0, '0);
			end
		end

		// drop valid, let the receiver drain, then idle before finishing
		request_valid <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("indexed_ordered_list_unit_test: done, clean");
		else
			$display("indexed_ordered_list_unit_test: done, errors");
		$finish;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#2000000;
		$display("indexed_ordered_list_unit_test: done, errors");
		$finish;
	end

endmodule
